// ----- rtl/wssp_pkg.sv -----
// Shared types and constants of the wheel speed sync PID controller.
// No dependencies; every other file of the block imports this package.
package wssp_pkg;

   localparam int CNT_W       = 8;    // per-wheel edge count
   localparam int ERR_W       = 9;    // count_a - count_b
   localparam int GAIN_W      = 16;   // signed Q8.8 gains
   localparam int DUTY_W      = 15;   // unsigned Q7.8 duty
   localparam int ACC_W       = 16;   // signed Q8.8 leaky accumulator
   localparam int ACC_MAG_W   = 17;   // |acc + err*256| < 2^17
   localparam int DP_W        = 26;   // deriv_gain * (err + prev_err)
   localparam int DP_MAG_W    = 24;   // |deriv product| < 2^24
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_MAX   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_START = 3'd4;

   localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 16'sd256;
   localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = 16'sd0;
   localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = 16'sd256;
   localparam logic [DUTY_W-1:0]        DUTY_MAX_RST   = 15'd6400;
   localparam logic [DUTY_W-1:0]        DUTY_START_RST = 15'd6400;

   typedef struct packed {
      logic [CNT_W-1:0] count_b;
      logic [CNT_W-1:0] count_a;
   } window_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] prop_gain;
      logic signed [GAIN_W-1:0] integ_gain;
      logic signed [GAIN_W-1:0] deriv_gain;
      logic [DUTY_W-1:0]        duty_max;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [DUTY_W-1:0] value;
   } duty_load_type;

   typedef struct packed {
      logic       push;
      window_type win;
   } queue_wr_type;

   typedef struct packed {
      logic       empty;
      window_type win;
   } queue_rd_type;

endpackage

// ----- rtl/wssp_front.sv -----
// Front end: edge detection and per-wheel edge counting on each sample word.
// Closes a window when wheel A reaches WINDOW_EDGES and queues the counts.
// Depends on wssp_pkg.
module wssp_front
   import wssp_pkg::*;
#(
   parameter int WINDOW_EDGES = 5
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         level_a,
   input  logic         level_b,
   input  logic         queue_full,
   output queue_wr_type queue_wr
);

   logic             last_a_ff, last_b_ff;
   logic [CNT_W-1:0] cnt_a_ff, cnt_b_ff;
   logic [CNT_W-1:0] cnt_a_in, cnt_b_in;
   logic             inc_a, inc_b, close, accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      inc_a    = level_a && !last_a_ff && (cnt_a_ff != CNT_MAX);
      inc_b    = level_b && !last_b_ff && (cnt_b_ff != CNT_MAX);
      cnt_a_in = cnt_a_ff + CNT_W'(inc_a);
      cnt_b_in = cnt_b_ff + CNT_W'(inc_b);
      close    = (cnt_a_in >= CNT_W'(WINDOW_EDGES));
      queue_wr.push          = accept && close;
      queue_wr.win.count_a   = cnt_a_in;
      queue_wr.win.count_b   = cnt_b_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_a_ff <= 1'b0;
         last_b_ff <= 1'b0;
         cnt_a_ff  <= '0;
         cnt_b_ff  <= '0;
      end else if (accept) begin
         last_a_ff <= level_a;
         last_b_ff <= level_b;
         // clear both counts once the window is handed off
         cnt_a_ff  <= close ? '0 : cnt_a_in;
         cnt_b_ff  <= close ? '0 : cnt_b_in;
      end
   end

endmodule

// ----- rtl/wssp_queue.sv -----
// Short queue of closed windows between the front end and the PID back end.
// Depends on wssp_pkg.
module wssp_queue
   import wssp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  queue_wr_type queue_wr,
   input  logic         pop,
   output logic         full,
   output queue_rd_type queue_rd
);

   window_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] fill_ff;
   logic                   do_push, do_pop;

   assign full           = (fill_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign queue_rd.empty = (fill_ff == '0);
   assign queue_rd.win   = mem_ff[rd_ptr_ff];
   assign do_push        = queue_wr.push && !full;
   assign do_pop         = pop && !queue_rd.empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= queue_wr.win;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   fill_ff <= fill_ff + 1'b1;
            2'b01:   fill_ff <= fill_ff - 1'b1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

endmodule

// ----- rtl/wssp_back.sv -----
// Back end: PID update per closed window, duty state and the result register.
// Divisions by WINDOW_EDGES use a reciprocal multiply on magnitudes.
// Depends on wssp_pkg.
module wssp_back
   import wssp_pkg::*;
#(
   parameter int WINDOW_EDGES = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  duty_load_type          duty_load,
   input  queue_rd_type           queue_rd,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int WIN_LOG = $clog2(WINDOW_EDGES);
   localparam int SHIFT_A = ACC_MAG_W + WIN_LOG;
   localparam int SHIFT_D = DP_MAG_W + WIN_LOG;
   localparam int QA_W    = ACC_MAG_W + SHIFT_A;
   localparam int QD_W    = DP_MAG_W + SHIFT_D;
   localparam logic [63:0] RECIP_A_FULL =
      ((64'd1 << SHIFT_A) + 64'(WINDOW_EDGES) - 64'd1) / 64'(WINDOW_EDGES);
   localparam logic [63:0] RECIP_D_FULL =
      ((64'd1 << SHIFT_D) + 64'(WINDOW_EDGES) - 64'd1) / 64'(WINDOW_EDGES);
   localparam logic [ACC_MAG_W:0] RECIP_A = RECIP_A_FULL[ACC_MAG_W:0];
   localparam logic [DP_MAG_W:0]  RECIP_D = RECIP_D_FULL[DP_MAG_W:0];

   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_MULT  = 3'd1;
   localparam logic [2:0] PH_RECIP = 3'd2;
   localparam logic [2:0] PH_SCALE = 3'd3;
   localparam logic [2:0] PH_INTEG = 3'd4;
   localparam logic [2:0] PH_DONE  = 3'd5;

   logic [2:0] phase_ff, phase_in;
   logic       rsp_tvalid_ff, rsp_tvalid_in;
   logic       out_free, done_fire;

   // loop state
   logic signed [ERR_W-1:0] prev_err_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [DUTY_W-1:0]       duty_ff;

   // stage registers
   logic [CNT_W-1:0]        edges_a_ff, edges_b_ff;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic signed [ACC_MAG_W:0] n_ff, n_in;
   logic signed [DP_W-1:0]  dp_ff, dp_in;
   logic signed [24:0]      pp_ff, pp_in;
   logic                    n_neg_ff, dp_neg_ff;
   logic [QA_W-1:0]         qa_ff, qa_in;
   logic [QD_W-1:0]         qd_ff, qd_in;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [24:0]      dterm_ff, dterm_in;
   logic signed [31:0]      ip_ff, ip_in;
   logic signed [DP_W-1:0]  pd_ff, pd_in;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff;

   // combinational helpers
   logic signed [GAIN_W-1:0]  prop_s, integ_s, deriv_s;
   logic signed [ERR_W:0]     dsum;
   logic signed [ACC_MAG_W:0] n_abs;
   logic [ACC_MAG_W-1:0]      n_mag, qa_q;
   logic signed [DP_W-1:0]    dp_abs;
   logic [DP_MAG_W-1:0]       dp_mag, qd_q;
   logic signed [ACC_MAG_W:0] acc_full;
   logic signed [31:0]        ip_adj;
   logic signed [23:0]        iterm;
   logic signed [27:0]        sum_s, dmax_s;
   logic [DUTY_W-1:0]         duty_clamp;

   assign prop_s  = cfg.prop_gain;
   assign integ_s = cfg.integ_gain;
   assign deriv_s = cfg.deriv_gain;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign done_fire  = (phase_ff == PH_DONE) && out_free;
   assign pop        = (phase_ff == PH_IDLE) && !queue_rd.empty;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      case (phase_ff)
         PH_IDLE:  phase_in = queue_rd.empty ? PH_IDLE : PH_MULT;
         PH_MULT:  phase_in = PH_RECIP;
         PH_RECIP: phase_in = PH_SCALE;
         PH_SCALE: phase_in = PH_INTEG;
         PH_INTEG: phase_in = PH_DONE;
         PH_DONE:  phase_in = out_free ? PH_IDLE : PH_DONE;
         default:  phase_in = PH_IDLE;
      endcase
      if (done_fire) begin
         rsp_tvalid_in = 1'b1;
      end else begin
         rsp_tvalid_in = rsp_tready ? 1'b0 : rsp_tvalid_ff;
      end
   end

   always_comb begin
      err_in = {1'b0, queue_rd.win.count_a} - {1'b0, queue_rd.win.count_b};

      // acc + err * 256, and the derivative and proportional products
      n_in  = {{(ACC_MAG_W + 1 - ACC_W){acc_ff[ACC_W-1]}}, acc_ff}
            + {err_ff[ERR_W-1], err_ff, 8'b0};
      dsum  = {err_ff[ERR_W-1], err_ff} + {prev_err_ff[ERR_W-1], prev_err_ff};
      dp_in = deriv_s * dsum;
      pp_in = prop_s * err_ff;

      // divide magnitudes by WINDOW_EDGES, truncating toward zero
      n_abs  = n_ff[ACC_MAG_W] ? -n_ff : n_ff;
      n_mag  = n_abs[ACC_MAG_W-1:0];
      qa_in  = QA_W'(n_mag) * QA_W'(RECIP_A);
      dp_abs = dp_ff[DP_W-1] ? -dp_ff : dp_ff;
      dp_mag = dp_abs[DP_MAG_W-1:0];
      qd_in  = QD_W'(dp_mag) * QD_W'(RECIP_D);

      qa_q     = qa_ff[SHIFT_A +: ACC_MAG_W];
      acc_full = n_neg_ff ? -{1'b0, qa_q} : {1'b0, qa_q};
      if (acc_full > 18'sd32767) begin
         acc_in = 16'sh7FFF;
      end else if (acc_full < -18'sd32768) begin
         acc_in = 16'sh8000;
      end else begin
         acc_in = acc_full[ACC_W-1:0];
      end
      qd_q     = qd_ff[SHIFT_D +: DP_MAG_W];
      dterm_in = dp_neg_ff ? -{1'b0, qd_q} : {1'b0, qd_q};

      ip_in = integ_s * acc_ff;
      pd_in = {pp_ff[24], pp_ff} + {dterm_ff[24], dterm_ff};

      // integral term: Q16.16 product back to Q8.8, toward zero
      ip_adj = ip_ff[31] ? ip_ff + 32'sd255 : ip_ff;
      iterm  = ip_adj[31:8];
      sum_s  = {13'b0, duty_ff} + {{2{pd_ff[DP_W-1]}}, pd_ff} + {{4{iterm[23]}}, iterm};
      dmax_s = {13'b0, cfg.duty_max};
      if (sum_s < 28'sd0) begin
         duty_clamp = '0;
      end else if (sum_s > dmax_s) begin
         duty_clamp = cfg.duty_max;
      end else begin
         duty_clamp = sum_s[DUTY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         rsp_tvalid_ff <= 1'b0;
         prev_err_ff   <= '0;
         acc_ff        <= '0;
         duty_ff       <= DUTY_START_RST;
      end else begin
         phase_ff      <= phase_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (phase_ff == PH_MULT) begin
            prev_err_ff <= err_ff;
         end
         if (phase_ff == PH_SCALE) begin
            acc_ff <= acc_in;
         end
         if (duty_load.valid) begin
            duty_ff <= duty_load.value;
         end else if (done_fire) begin
            duty_ff <= duty_clamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         edges_a_ff <= queue_rd.win.count_a;
         edges_b_ff <= queue_rd.win.count_b;
         err_ff     <= err_in;
      end
      if (phase_ff == PH_MULT) begin
         n_ff  <= n_in;
         dp_ff <= dp_in;
         pp_ff <= pp_in;
      end
      if (phase_ff == PH_RECIP) begin
         n_neg_ff  <= n_ff[ACC_MAG_W];
         dp_neg_ff <= dp_ff[DP_W-1];
         qa_ff     <= qa_in;
         qd_ff     <= qd_in;
      end
      if (phase_ff == PH_SCALE) begin
         dterm_ff <= dterm_in;
      end
      if (phase_ff == PH_INTEG) begin
         ip_ff <= ip_in;
         pd_ff <= pd_in;
      end
      if (done_fire) begin
         rsp_data_ff <= {1'b0, edges_b_ff, edges_a_ff, duty_clamp};
      end
   end

endmodule

// ----- rtl/wheel_speed_sync_pid.sv -----
// wheel_speed_sync_pid: keeps wheel B in step with wheel A by a PID on
// per-window encoder edge counts.
//
// req_* takes one encoder sample word (level_a, level_b) per cycle while
// req_tready is high. Rising edges are counted per wheel; when wheel A reaches
// WINDOW_EDGES the window closes and one rsp_* word follows with the new wheel B
// duty and both counts. Samples that do not close a window give no result.
// The csr_* port writes the gains, the duty clamp and the start duty; writing
// the start duty also loads the running duty at once.
// Throughput: one sample per cycle while req_tready is high. The PID back end
// takes one window at a time (the pop from idle, four stages around its
// multiplies and the result handoff); a 4-deep window queue sits in front of it,
// so req_tready drops only when that queue fills: when windows close faster than
// the back end, possible for WINDOW_EDGES below 3, or when rsp_tready holds off
// for several windows. A closing sample passes the window queue, the back end
// phases and the result register before it shows on rsp_tvalid.
// Reset clears counts, accumulator and previous error, and sets the duty to
// the reset start duty. When rsp_tready is low the result word holds in the
// output register while samples keep flowing into the queue until it fills.
module wheel_speed_sync_pid
   import wssp_pkg::*;
#(
   parameter int WINDOW_EDGES = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [0] level_a, [1] level_b
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [14:0] duty_out, [22:15] edges_a,
                                               // [30:23] edges_b
   input  logic                   csr_wen,
   input  logic [CSR_IDX_W-1:0]   csr_idx,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type       cfg_ff;
   duty_load_type duty_load;
   queue_wr_type  queue_wr;
   queue_rd_type  queue_rd;
   logic          queue_full, queue_pop;

   assign duty_load.valid = csr_wen && (csr_idx == CSR_DUTY_START);
   assign duty_load.value = csr_wdata[DUTY_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain  <= PROP_GAIN_RST;
         cfg_ff.integ_gain <= INTEG_GAIN_RST;
         cfg_ff.deriv_gain <= DERIV_GAIN_RST;
         cfg_ff.duty_max   <= DUTY_MAX_RST;
      end else if (csr_wen) begin
         case (csr_idx)
            CSR_PROP_GAIN:  cfg_ff.prop_gain  <= csr_wdata;
            CSR_INTEG_GAIN: cfg_ff.integ_gain <= csr_wdata;
            CSR_DERIV_GAIN: cfg_ff.deriv_gain <= csr_wdata;
            CSR_DUTY_MAX:   cfg_ff.duty_max   <= csr_wdata[DUTY_W-1:0];
            default:        cfg_ff            <= cfg_ff;
         endcase
      end
   end

   wssp_front #(
      .WINDOW_EDGES (WINDOW_EDGES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .level_a    (req_tdata[0]),
      .level_b    (req_tdata[1]),
      .queue_full (queue_full),
      .queue_wr   (queue_wr)
   );

   wssp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .queue_wr (queue_wr),
      .pop      (queue_pop),
      .full     (queue_full),
      .queue_rd (queue_rd)
   );

   wssp_back #(
      .WINDOW_EDGES (WINDOW_EDGES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .duty_load  (duty_load),
      .queue_rd   (queue_rd),
      .pop        (queue_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
